FILE: src/signed_decimal_to_seven_segment_assert.svh
// Assertion macros shared by the display writer RTL.
`ifndef SIGNED_DECIMAL_TO_SEVEN_SEGMENT_ASSERT_SVH
`define SIGNED_DECIMAL_TO_SEVEN_SEGMENT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sds_pkg.sv
// Types, constants and the segment table of the display writer.
`default_nettype none
package sds_pkg;

  localparam int unsigned MaxDigits = 8;
  localparam int unsigned DigIdxW   = 3;
  localparam int unsigned FifoDepth = 2;

  localparam logic [3:0]  TopAddr      = 4'd8;
  localparam logic [7:0]  MinusPattern = 8'h01;
  localparam logic [7:0]  BlankPattern = 8'h00;
  localparam logic [31:0] RecipTen     = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift   = 35;

  typedef enum logic {
    FR_IDLE,
    FR_CONV
  } front_state_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  // one converted number, digits least significant first
  typedef struct packed {
    logic [MaxDigits-1:0][3:0] digs;
    logic                      neg;
    logic                      show;
    logic [3:0]                len;
    logic [3:0]                first;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // XABCDEFG pattern of one decimal digit
  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'h7E;
      4'd1:    p = 8'h30;
      4'd2:    p = 8'h6D;
      4'd3:    p = 8'h79;
      4'd4:    p = 8'h33;
      4'd5:    p = 8'h5B;
      4'd6:    p = 8'h5F;
      4'd7:    p = 8'h70;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h7B;
      default: p = BlankPattern;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: src/sds_front.sv
// Front end: accepts numbers, clamps the field and converts to decimal digits.
`default_nettype none
module sds_front #(
  parameter int unsigned DIGITS = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [47:0]           s_axis_tdata,
  output logic                       push_o,
  output sds_pkg::entry_t            entry_o,
  input  wire sds_pkg::fifo_status_t fifo_st_i
);

  localparam logic [4:0] DigitsW = 5'(DIGITS);
  localparam logic [3:0] LastPos = 4'(DIGITS - 1);

  sds_pkg::front_state_e state_q, state_d;

  logic [31:0] num, mag_in;
  logic        neg_in, show_in, accept, done, conv_en;
  logic [3:0]  len_in, pos_in, pos_c, len_c, len_adj;
  logic [4:0]  span;

  logic [31:0] mag_q;
  logic [3:0]  len_q, first_q, cnt_q;
  logic        neg_q, show_q;
  logic [sds_pkg::MaxDigits-1:0][3:0] digs_q;

  logic [63:0] prod;
  logic [31:0] quot, rem_full;

  assign num     = s_axis_tdata[31:0];
  assign show_in = s_axis_tdata[32];
  assign len_in  = s_axis_tdata[36:33];
  assign pos_in  = s_axis_tdata[40:37];
  assign neg_in  = num[31];
  assign mag_in  = neg_in ? (32'd0 - num) : num;

  // clamp position, then length to what is left of the display
  assign pos_c   = (5'(pos_in) >= DigitsW) ? LastPos : pos_in;
  assign span    = 5'(pos_c) + 5'(len_in);
  assign len_c   = (span > DigitsW) ? 4'(DigitsW - 5'(pos_c)) : len_in;
  assign len_adj = (neg_in && (len_c != 4'd0)) ? (len_c - 4'd1) : len_c;

  // divide by ten through the reciprocal
  assign prod     = 64'(mag_q) * 64'(sds_pkg::RecipTen);
  assign quot     = 32'(prod >> sds_pkg::RecipShift);
  assign rem_full = mag_q - ((quot << 3) + (quot << 1));

  assign done   = (cnt_q == len_q);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sds_pkg::FR_IDLE: begin
        if (accept) state_d = sds_pkg::FR_CONV;
      end
      sds_pkg::FR_CONV: begin
        if (push_o) state_d = accept ? sds_pkg::FR_CONV : sds_pkg::FR_IDLE;
      end
      default: state_d = sds_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    push_o        = 1'b0;
    conv_en       = 1'b0;
    unique case (state_q)
      sds_pkg::FR_IDLE: s_axis_tready = 1'b1;
      sds_pkg::FR_CONV: begin
        push_o        = done && !fifo_st_i.full;
        s_axis_tready = done && !fifo_st_i.full;
        conv_en       = !done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sds_pkg::FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (conv_en) begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q   <= mag_in;
      len_q   <= len_adj;
      first_q <= sds_pkg::TopAddr - pos_c;
      neg_q   <= neg_in;
      show_q  <= show_in;
    end else if (conv_en) begin
      mag_q                                 <= quot;
      digs_q[cnt_q[sds_pkg::DigIdxW-1:0]]   <= rem_full[3:0];
    end
  end

  always_comb begin
    entry_o.digs  = digs_q;
    entry_o.neg   = neg_q;
    entry_o.show  = show_q;
    entry_o.len   = len_q;
    entry_o.first = first_q;
  end

endmodule
`default_nettype wire

FILE: src/sds_fifo.sv
// Short queue of converted numbers between front and back.
`default_nettype none
module sds_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire sds_pkg::entry_t entry_i,
  input  wire logic            pop_i,
  output sds_pkg::entry_t      entry_o,
  output sds_pkg::fifo_status_t status_o
);

  localparam int unsigned PtrW = $clog2(sds_pkg::FifoDepth);
  localparam logic [PtrW:0] DepthC = (PtrW + 1)'(sds_pkg::FifoDepth);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(sds_pkg::FifoDepth - 1);

  sds_pkg::entry_t mem_q [sds_pkg::FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == DepthC);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

endmodule
`default_nettype wire

FILE: src/sds_back.sv
// Back end: emits sign and digit register writes, one beat per cycle while m_axis_tready holds high.
`default_nettype none
module sds_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sds_pkg::entry_t       entry_i,
  input  wire sds_pkg::fifo_status_t fifo_st_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [15:0]                m_axis_tdata,
  output logic                       m_axis_tlast
);

  sds_pkg::back_state_e state_q, state_d;

  logic [sds_pkg::MaxDigits-1:0][3:0] digs_q;
  logic [sds_pkg::DigIdxW-1:0] didx_q;
  logic [3:0]  rem_q, addr_q;
  logic        sign_q, showing_q;

  logic        tvalid_q, tlast_q;
  logic [3:0]  oaddr_q;
  logic [7:0]  odata_q;

  logic        slot_free, emit, has_writes, beat_last, blank;
  logic [3:0]  dig;
  logic [7:0]  beat_data;

  assign slot_free  = !tvalid_q || m_axis_tready;
  assign has_writes = entry_i.neg || (entry_i.len != 4'd0);
  assign dig        = digs_q[didx_q];
  assign beat_last  = sign_q ? (rem_q == 4'd0) : (rem_q == 4'd1);
  // leading zeros blank until a nonzero digit, last digit always shows
  assign blank      = !showing_q && (dig == 4'd0) && (rem_q != 4'd1);
  assign beat_data  = sign_q ? sds_pkg::MinusPattern :
                      blank  ? sds_pkg::BlankPattern : sds_pkg::seg_pattern(dig);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sds_pkg::BK_IDLE: begin
        if (pop_o && has_writes) state_d = sds_pkg::BK_RUN;
      end
      sds_pkg::BK_RUN: begin
        if (emit && beat_last) state_d = sds_pkg::BK_IDLE;
      end
      default: state_d = sds_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    emit  = 1'b0;
    unique case (state_q)
      sds_pkg::BK_IDLE: pop_o = !fifo_st_i.empty;
      sds_pkg::BK_RUN:  emit  = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sds_pkg::BK_IDLE;
      tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      digs_q    <= entry_i.digs;
      didx_q    <= sds_pkg::DigIdxW'(entry_i.len - 4'd1);
      rem_q     <= entry_i.len;
      addr_q    <= entry_i.first;
      sign_q    <= entry_i.neg;
      showing_q <= entry_i.show;
    end else if (emit) begin
      addr_q <= addr_q - 4'd1;
      if (sign_q) begin
        sign_q <= 1'b0;
      end else begin
        rem_q     <= rem_q - 4'd1;
        didx_q    <= didx_q - 1'b1;
        showing_q <= showing_q || (dig != 4'd0);
      end
    end
    if (emit) begin
      oaddr_q <= addr_q;
      odata_q <= beat_data;
      tlast_q <= beat_last;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = {4'd0, odata_q, oaddr_q};
  assign m_axis_tlast  = tlast_q;

endmodule
`default_nettype wire

FILE: src/signed_decimal_to_seven_segment.sv
// Top level of the signed decimal to seven-segment register writer.
//
// Input stream (s_axis): one beat per number to show. Output stream (m_axis):
// the digit register writes it causes, tlast on the final write of a number.
// A negative number writes the minus pattern first at the field start.
// Numbers with zero length that are not negative cause no beats at all.
//
// The front converts the magnitude to decimal, one digit per cycle with a
// reciprocal multiply that divides by ten. A two-entry queue decouples it
// from the back, which takes an entry only when it is idle and then emits
// the writes of that number while m_axis_tready allows, so it finishes one
// number before it takes the next.
//
// Reset empties the queue and both sequencers; no beat is lost across
// a stall. When m_axis_tready is low the output register holds its beat,
// the back waits, and once the queue fills the front drops s_axis_tready.
`default_nettype none
module signed_decimal_to_seven_segment #(
  parameter int unsigned DIGITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // number[31:0], show_leading_zeros[32], field_length[36:33],
  // start_position[40:37], zero fill above
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // reg_addr[3:0], reg_data[11:4], zero fill above
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  `include "signed_decimal_to_seven_segment_assert.svh"

  logic                  push, pop;
  sds_pkg::entry_t       push_entry, head_entry;
  sds_pkg::fifo_status_t fifo_st;

  // classify and convert
  sds_front #(
    .DIGITS(DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .push_o       (push),
    .entry_o      (push_entry),
    .fifo_st_i    (fifo_st)
  );

  // converted numbers waiting for the writer
  sds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .status_o(fifo_st)
  );

  // register write sequencer with output register
  sds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (head_entry),
    .fifo_st_i    (fifo_st),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // front never pushes into a full queue
  `SDS_ASSERT_IMPL(a_push_not_full, clk_i, rst_ni, push, !fifo_st.full, "push into full queue")
  // back only takes an entry that is there
  `SDS_ASSERT_IMPL(a_pop_not_empty, clk_i, rst_ni, pop, !fifo_st.empty, "pop from empty queue")
  // digit addresses stay within the display
  `SDS_ASSERT_IMPL(a_addr_range, clk_i, rst_ni, m_axis_tvalid,
    (m_axis_tdata[3:0] != 4'd0) && (m_axis_tdata[3:0] <= sds_pkg::TopAddr),
    "digit address out of range")
  // a pushed entry leaves the queue non-empty
  `SDS_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, push && !pop, !fifo_st.empty,
    "queue empty after push")

endmodule
`default_nettype wire
